/* rtl/core/atd_pkg.sv */
// Shared constants, types and the microcode store for the date adder.
`default_nettype none

package atd_pkg;

    // Datapath widths
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned ADD_W   = 14;
    // Remainder: 31 + 366 + 16383 fits in 15 bits
    localparam int unsigned REM_W   = 15;
    // Working year: 16383 plus about 46 years of rollover
    localparam int unsigned WYEAR_W = 15;
    // Quotient by 100 of the working year
    localparam int unsigned Q_W     = 9;
    localparam int unsigned PROD_W  = 28;
    // year / 100 == (year * 5243) >> 19, exact for year below 43699
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam int unsigned DIV100_SHR = 19;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   FEB_LEAP  = 5'd29;
    localparam logic [DAY_W-1:0]   FEB_PLAIN = 5'd28;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Step counter
    localparam int unsigned PC_W = 3;
    localparam logic [PC_W-1:0] PC_LOAD = 3'd0;
    localparam logic [PC_W-1:0] PC_PRE  = 3'd1;
    localparam logic [PC_W-1:0] PC_ADD  = 3'd2;
    localparam logic [PC_W-1:0] PC_WALK = 3'd3;
    localparam logic [PC_W-1:0] PC_EMIT = 3'd4;

    // Jump conditions
    localparam logic [2:0] COND_NEVER    = 3'd0;
    localparam logic [2:0] COND_IN_VALID = 3'd1;
    localparam logic [2:0] COND_PRE_DONE = 3'd2;
    localparam logic [2:0] COND_FITS     = 3'd3;
    localparam logic [2:0] COND_OUT_FREE = 3'd4;

    // Datapath operations
    localparam logic [2:0] OP_NOP  = 3'd0;
    localparam logic [2:0] OP_LOAD = 3'd1;
    localparam logic [2:0] OP_PRE  = 3'd2;
    localparam logic [2:0] OP_ADD  = 3'd3;
    localparam logic [2:0] OP_WALK = 3'd4;
    localparam logic [2:0] OP_EMIT = 3'd5;

    typedef struct packed {
        logic [2:0]      cond;
        logic [2:0]      op;
        logic [PC_W-1:0] jump;
        logic [PC_W-1:0] next;
    } t_ucode;

    // Control store: on cond go to jump, else to next
    function automatic t_ucode ucode_rom(input logic [PC_W-1:0] pc);
        t_ucode uc;
        uc.cond = COND_NEVER;
        uc.op   = OP_NOP;
        uc.jump = PC_LOAD;
        uc.next = PC_LOAD;
        case (pc)
            PC_LOAD: begin
                uc.cond = COND_IN_VALID; uc.op = OP_LOAD;
                uc.jump = PC_PRE;        uc.next = PC_LOAD;
            end
            PC_PRE: begin
                uc.cond = COND_PRE_DONE; uc.op = OP_PRE;
                uc.jump = PC_ADD;        uc.next = PC_PRE;
            end
            PC_ADD: begin
                uc.cond = COND_NEVER;    uc.op = OP_ADD;
                uc.jump = PC_WALK;       uc.next = PC_WALK;
            end
            PC_WALK: begin
                uc.cond = COND_FITS;     uc.op = OP_WALK;
                uc.jump = PC_EMIT;       uc.next = PC_WALK;
            end
            PC_EMIT: begin
                uc.cond = COND_OUT_FREE; uc.op = OP_EMIT;
                uc.jump = PC_LOAD;       uc.next = PC_EMIT;
            end
            default: begin
                uc.cond = COND_NEVER;    uc.op = OP_NOP;
                uc.jump = PC_LOAD;       uc.next = PC_LOAD;
            end
        endcase
        return uc;
    endfunction

    // Month length; zero for a month code outside 1..12
    function automatic logic [DAY_W-1:0] days_in_month(
        input logic [MONTH_W-1:0] m,
        input logic               leap
    );
        logic [MONTH_W-1:0] idx;
        idx = m - MONTH_JAN;
        if (m < MONTH_JAN || m > MONTH_DEC) begin
            return '0;
        end
        if (m == MONTH_FEB) begin
            return leap ? FEB_LEAP : FEB_PLAIN;
        end
        return MONTH_LEN[idx];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/atd_if.sv */
// Valid/ready channels for the start date request and the result date.
`default_nettype none

interface atd_req_if;
    logic                            valid;
    logic                            ready;
    logic [atd_pkg::DAY_W-1:0]       start_day;
    logic [atd_pkg::MONTH_W-1:0]     start_month;
    logic [atd_pkg::YEAR_W-1:0]      start_year;
    logic [atd_pkg::ADD_W-1:0]       days_to_add;

    modport source(output valid, start_day, start_month, start_year, days_to_add,
                   input ready);
    modport sink(input valid, start_day, start_month, start_year, days_to_add,
                 output ready);
endinterface

interface atd_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [atd_pkg::DAY_W-1:0]       result_day;
    logic [atd_pkg::MONTH_W-1:0]     result_month;
    logic [atd_pkg::YEAR_W-1:0]      result_year;

    modport source(output valid, result_day, result_month, result_year,
                   input ready);
    modport sink(input valid, result_day, result_month, result_year,
                 output ready);
endinterface

`default_nettype wire

/* rtl/core/add_days_to_date.sv */
// Top level: Gregorian date plus a day count, run by a microcoded sequencer.
//
//  Channel  Dir  Payload                                          Accepted when
//  i_req    in   start_day, start_month, start_year, days_to_add  valid & ready
//  o_rsp    out  result_day, result_month, result_year            valid & ready
//
// A transaction runs the load step, the prefix sum over the months before start_month,
// the add step, the month walk and the emit step; the walk goes one month per step.
// Each step of the walk does one subtract of a month length from the remainder.
// i_req.ready is high only at the load step; a result waiting on o_rsp holds
// the sequencer at its emit step. Reset is synchronous and clears the step
// counter and the output valid.
`default_nettype none

module add_days_to_date (
    input  wire          i_clk,
    input  wire          i_rst_n,
    atd_req_if.sink      i_req,
    atd_rsp_if.source    o_rsp
);

    // Sequencer state
    logic [atd_pkg::PC_W-1:0]    r_pc;
    logic [atd_pkg::PC_W-1:0]    n_pc;
    logic                        r_ovalid;

    // Datapath registers
    logic [atd_pkg::REM_W-1:0]   r_rem;
    logic [atd_pkg::MONTH_W-1:0] r_m;
    logic [atd_pkg::MONTH_W-1:0] r_month;
    logic [atd_pkg::WYEAR_W-1:0] r_year;
    logic [atd_pkg::ADD_W-1:0]   r_add;
    logic [atd_pkg::Q_W-1:0]     r_q;
    logic [atd_pkg::DAY_W-1:0]   r_oday;
    logic [atd_pkg::MONTH_W-1:0] r_omonth;
    logic [atd_pkg::YEAR_W-1:0]  r_oyear;

    atd_pkg::t_ucode             w_uc;
    logic                        w_cond;
    logic                        w_leap;
    logic [atd_pkg::DAY_W-1:0]   w_len;
    logic [atd_pkg::PROD_W-1:0]  w_prod;
    logic [atd_pkg::WYEAR_W-1:0] w_q100;
    logic                        w_out_free;

    // Control word fetch
    assign w_uc = atd_pkg::ucode_rom(r_pc);
    assign w_out_free = !r_ovalid || o_rsp.ready;

    // Leap test: quotient by 100 is registered, the rest is shift and compare
    assign w_prod = atd_pkg::PROD_W'(r_year) * atd_pkg::PROD_W'(atd_pkg::DIV100_MUL);
    assign w_q100 = (atd_pkg::WYEAR_W'(r_q) << 6) + (atd_pkg::WYEAR_W'(r_q) << 5)
                  + (atd_pkg::WYEAR_W'(r_q) << 2);
    assign w_leap = (r_year[1:0] == 2'b00) && ((r_year != w_q100) || (r_q[1:0] == 2'b00));
    assign w_len  = atd_pkg::days_in_month(r_m, w_leap);

    // Condition select
    always_comb begin
        case (w_uc.cond)
            atd_pkg::COND_NEVER:    w_cond = 1'b0;
            atd_pkg::COND_IN_VALID: w_cond = i_req.valid;
            atd_pkg::COND_PRE_DONE: w_cond = (r_m >= r_month) || (r_m > atd_pkg::MONTH_DEC);
            atd_pkg::COND_FITS:     w_cond = (r_rem <= atd_pkg::REM_W'(w_len));
            atd_pkg::COND_OUT_FREE: w_cond = w_out_free;
            default:                w_cond = 1'b0;
        endcase
    end

    assign n_pc = w_cond ? w_uc.jump : w_uc.next;

    // Step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= atd_pkg::PC_LOAD;
            r_ovalid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (w_uc.op == atd_pkg::OP_EMIT && w_cond) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Quotient by 100 of the working year, held in a register that lags it
    always_ff @(posedge i_clk) begin
        r_q <= atd_pkg::Q_W'(w_prod >> atd_pkg::DIV100_SHR);
    end

    // Datapath driven by the control word
    always_ff @(posedge i_clk) begin
        case (w_uc.op)
            atd_pkg::OP_LOAD: begin
                if (w_cond) begin
                    r_rem   <= atd_pkg::REM_W'(i_req.start_day);
                    r_m     <= atd_pkg::MONTH_JAN;
                    r_month <= i_req.start_month;
                    r_year  <= atd_pkg::WYEAR_W'(i_req.start_year);
                    r_add   <= i_req.days_to_add;
                end
            end
            atd_pkg::OP_PRE: begin
                if (!w_cond) begin
                    r_rem <= r_rem + atd_pkg::REM_W'(w_len);
                    r_m   <= r_m + atd_pkg::MONTH_W'(1);
                end
            end
            atd_pkg::OP_ADD: begin
                r_rem <= r_rem + atd_pkg::REM_W'(r_add);
                r_m   <= atd_pkg::MONTH_JAN;
            end
            atd_pkg::OP_WALK: begin
                if (!w_cond) begin
                    r_rem <= r_rem - atd_pkg::REM_W'(w_len);
                    if (r_m == atd_pkg::MONTH_DEC) begin
                        r_m    <= atd_pkg::MONTH_JAN;
                        r_year <= r_year + atd_pkg::WYEAR_W'(1);
                    end else begin
                        r_m <= r_m + atd_pkg::MONTH_W'(1);
                    end
                end
            end
            atd_pkg::OP_EMIT: begin
                if (w_cond) begin
                    r_oday   <= r_rem[atd_pkg::DAY_W-1:0];
                    r_omonth <= r_m;
                    r_oyear  <= r_year[atd_pkg::YEAR_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // Ports
    assign i_req.ready        = (r_pc == atd_pkg::PC_LOAD);
    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.result_day   = r_oday;
    assign o_rsp.result_month = r_omonth;
    assign o_rsp.result_year  = r_oyear;

    // Checks
    a_load_to_pre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_pc == atd_pkg::PC_PRE))
        else $error("accepted transaction did not start the prefix sum");

    a_walk_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == atd_pkg::PC_WALK) |-> (r_m >= atd_pkg::MONTH_JAN && r_m <= atd_pkg::MONTH_DEC))
        else $error("month walk left the range January to December");

    a_rise_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_pc) == atd_pkg::PC_EMIT))
        else $error("result valid raised outside the emit step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_rsp.ready) |=> ($stable(r_oday) && $stable(r_omonth)
                                         && $stable(r_oyear)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
